// ===== rtl/core/assert_macros.svh =====
// Assertion helpers that sample on the block clock and are disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LQR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("lqr: implication check failed");
`define LQR_ASSERT_DLY(label, ante, dly, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
	else $error("lqr: delayed check failed");
`else
`define LQR_ASSERT_IMP(label, ante, cons)
`define LQR_ASSERT_DLY(label, ante, dly, cons)
`endif
`endif

// ===== rtl/core/lqr_pkg.sv =====
`default_nettype none
package lqr_pkg;

	localparam int unsigned MAX_STATES = 4;
	localparam int unsigned MAX_DRIVES = 2;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned ERR_W = DATA_W + 1;
	localparam int unsigned SUM_W = 52;
	localparam int unsigned FRAC_DROP = 8;
	localparam int unsigned DRIVE_W = SUM_W - FRAC_DROP;
	localparam int unsigned LIMIT_W = DATA_W - 1;
	localparam int unsigned CFG_W = 64;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned REG_LSB = 3;
	localparam int unsigned REG_IDX_W = ADDR_W - REG_LSB;

	localparam logic [REG_IDX_W-1:0] REG_GAINS_FIRST = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_GAINS_SECOND = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DRIVE_LIMIT = 2'd2;

	typedef enum logic [1:0] {
		STATUS_OK = 2'd0,
		STATUS_LIMIT_ZERO = 2'd1,
		STATUS_SATURATED = 2'd2
	} status_t;

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [MAX_DRIVES-1:0][GAIN_W-1:0] gain_col_t;

	typedef struct packed {
		logic live;
		logic compute;
		logic limit_zero;
		logic enable;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		err_t [MAX_STATES-1:0] err;
		sum_t [MAX_DRIVES-1:0] sum;
	} bundle_t;

	typedef struct packed {
		logic [MAX_DRIVES-1:0][DATA_W-1:0] drive;
		logic valid;
		logic sat;
		logic enable;
		status_t code;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/core/lqr_state_feedback.sv =====
`default_nettype none
`include "assert_macros.svh"
// State-feedback drive unit. A request is taken on any cycle with start high; busy is always
// low, so one request per clock is sustained. A request passes through the input stage
// register, one register in each cell and the output stage register before its result is
// shown. It is held for exactly one cycle and marked by done; the receiver cannot stall it,
// so it must take every result on the cycle it is shown. Results leave in request order.
// The datapath is a chain of cells, one per state, each adding one gain-times-error product
// per drive to the running sums; an input stage forms the error and an output stage
// negates, floors and clamps. Gains lie at byte addresses 0x00 and 0x08 and the drive limit
// at 0x10; they should be changed only while no request is in flight.
module lqr_state_feedback
	import lqr_pkg::*;
#(
	parameter int unsigned STATE_COUNT = 4,
	parameter int unsigned DRIVE_COUNT = 2
)(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic signed [DATA_W-1:0] measured_0,
	input wire logic signed [DATA_W-1:0] measured_1,
	input wire logic signed [DATA_W-1:0] measured_2,
	input wire logic signed [DATA_W-1:0] measured_3,
	input wire logic signed [DATA_W-1:0] target_0,
	input wire logic signed [DATA_W-1:0] target_1,
	input wire logic signed [DATA_W-1:0] target_2,
	input wire logic signed [DATA_W-1:0] target_3,
	input wire logic run_enable,
	input wire logic clear_request,
	output logic done,
	output logic signed [DATA_W-1:0] drive_first,
	output logic signed [DATA_W-1:0] drive_second,
	output logic drives_valid,
	output logic clamped,
	output logic enabled_echo,
	output logic [1:0] status_code,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [CFG_W-1:0] pwdata,
	output logic [CFG_W-1:0] prdata,
	output logic pready
);

	localparam int unsigned LATENCY = STATE_COUNT + 2;

	logic [CFG_W-1:0] gains_first_q;
	logic [CFG_W-1:0] gains_second_q;
	logic [DATA_W-1:0] limit_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic cfg_write;
	logic [DATA_W-1:0] limit_neg;
	logic [LIMIT_W-1:0] limit_abs;

	logic signed [DATA_W-1:0] meas [MAX_STATES];
	logic signed [DATA_W-1:0] targ [MAX_STATES];
	bundle_t front_nxt;
	bundle_t front_s1;
	logic front_live_s1;
	bundle_t chain [STATE_COUNT+1];
	logic done_w;
	result_t result;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign reg_idx = paddr[ADDR_W-1:REG_LSB];
	assign cfg_write = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_first_q <= '0;
			gains_second_q <= '0;
			limit_q <= DATA_W'(65536);
		end else if (cfg_write) begin
			case (reg_idx)
				REG_GAINS_FIRST: gains_first_q <= pwdata;
				REG_GAINS_SECOND: gains_second_q <= pwdata;
				REG_DRIVE_LIMIT: limit_q <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAINS_FIRST: prdata = gains_first_q;
			REG_GAINS_SECOND: prdata = gains_second_q;
			REG_DRIVE_LIMIT: prdata = {{(CFG_W-DATA_W){1'b0}}, limit_q};
			default: prdata = '0;
		endcase
	end

	// The most negative limit has no positive twin and saturates to the largest drive.
	assign limit_neg = -limit_q;
	assign limit_abs = !limit_q[DATA_W-1] ? limit_q[LIMIT_W-1:0] :
		(limit_neg[DATA_W-1] ? {LIMIT_W{1'b1}} : limit_neg[LIMIT_W-1:0]);

	assign meas[0] = measured_0;
	assign meas[1] = measured_1;
	assign meas[2] = measured_2;
	assign meas[3] = measured_3;
	assign targ[0] = target_0;
	assign targ[1] = target_1;
	assign targ[2] = target_2;
	assign targ[3] = target_3;

	always_comb begin
		front_nxt = '0;
		front_nxt.ctrl.live = start & !busy;
		front_nxt.ctrl.enable = run_enable;
		front_nxt.ctrl.compute = !clear_request & run_enable & (limit_q != '0);
		front_nxt.ctrl.limit_zero = !clear_request & run_enable & (limit_q == '0);
		for (int k = 0; k < MAX_STATES; k++) begin
			front_nxt.err[k] = ERR_W'(meas[k]) - ERR_W'(targ[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_live_s1 <= 1'b0;
		end else begin
			front_live_s1 <= front_nxt.ctrl.live;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= front_nxt;
	end

	always_comb begin
		chain[0] = front_s1;
		chain[0].ctrl.live = front_live_s1;
	end

	for (genvar k = 0; k < STATE_COUNT; k++) begin : g_cell
		gain_col_t gains;

		assign gains[0] = gains_first_q[GAIN_W*k +: GAIN_W];
		assign gains[1] = gains_second_q[GAIN_W*k +: GAIN_W];

		lqr_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.in_bundle(chain[k]),
			.gains(gains),
			.out_bundle(chain[k+1])
		);
	end

	lqr_clamp #(
		.DRIVE_COUNT(DRIVE_COUNT)
	) u_clamp (
		.clk(clk),
		.arst_n(arst_n),
		.in_bundle(chain[STATE_COUNT]),
		.limit(limit_abs),
		.done(done_w),
		.result(result)
	);

	assign done = done_w;
	assign drive_first = result.drive[0];
	assign drive_second = result.drive[1];
	assign drives_valid = result.valid;
	assign clamped = result.sat;
	assign enabled_echo = result.enable;
	assign status_code = result.code;

	`LQR_ASSERT_DLY(a_request_returns, start && !busy, LATENCY, done)
	`LQR_ASSERT_IMP(a_result_has_request, done, $past(start, LATENCY))
	`LQR_ASSERT_IMP(a_sat_is_valid, done && status_code == STATUS_SATURATED,
		clamped && drives_valid)
	`LQR_ASSERT_IMP(a_idle_drives_zero, done && !drives_valid,
		drive_first == '0 && drive_second == '0 && !clamped)

endmodule
`default_nettype wire

// ===== rtl/core/lqr_cell.sv =====
`default_nettype none
module lqr_cell
	import lqr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire bundle_t in_bundle,
	input wire gain_col_t gains,
	output bundle_t out_bundle
);

	logic signed [ERR_W+GAIN_W-1:0] prod [MAX_DRIVES];
	bundle_t nxt;
	bundle_t data_s1;
	logic live_s1;

	always_comb begin
		nxt = in_bundle;
		for (int k = 0; k < MAX_STATES - 1; k++) begin
			nxt.err[k] = in_bundle.err[k+1];
		end
		nxt.err[MAX_STATES-1] = '0;
		for (int d = 0; d < MAX_DRIVES; d++) begin
			prod[d] = $signed(in_bundle.err[0]) * $signed(gains[d]);
			nxt.sum[d] = $signed(in_bundle.sum[d]) + SUM_W'(prod[d]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_s1 <= 1'b0;
		end else begin
			live_s1 <= nxt.ctrl.live;
		end
	end

	always_ff @(posedge clk) begin
		data_s1 <= nxt;
	end

	always_comb begin
		out_bundle = data_s1;
		out_bundle.ctrl.live = live_s1;
	end

endmodule
`default_nettype wire

// ===== rtl/core/lqr_clamp.sv =====
`default_nettype none
module lqr_clamp
	import lqr_pkg::*;
#(
	parameter int unsigned DRIVE_COUNT = 2
)(
	input wire logic clk,
	input wire logic arst_n,
	input wire bundle_t in_bundle,
	input wire logic [LIMIT_W-1:0] limit,
	output logic done,
	output result_t result
);

	logic signed [SUM_W-1:0] neg_sum [MAX_DRIVES];
	logic signed [DRIVE_W-1:0] floored [MAX_DRIVES];
	logic signed [DRIVE_W-1:0] lim_pos;
	logic signed [DRIVE_W-1:0] lim_neg;
	logic [MAX_DRIVES-1:0] hit;
	result_t nxt;
	result_t result_q;
	logic done_q;

	always_comb begin
		lim_pos = $signed({{(DRIVE_W-LIMIT_W){1'b0}}, limit});
		lim_neg = -lim_pos;
		nxt = '0;
		nxt.enable = in_bundle.ctrl.enable;
		nxt.code = in_bundle.ctrl.limit_zero ? STATUS_LIMIT_ZERO : STATUS_OK;
		for (int d = 0; d < MAX_DRIVES; d++) begin
			neg_sum[d] = -$signed(in_bundle.sum[d]);
			floored[d] = DRIVE_W'(neg_sum[d] >>> FRAC_DROP);
			hit[d] = 1'b0;
			if (d < DRIVE_COUNT && in_bundle.ctrl.compute) begin
				if (floored[d] > lim_pos) begin
					nxt.drive[d] = DATA_W'(lim_pos);
					hit[d] = 1'b1;
				end else if (floored[d] < lim_neg) begin
					nxt.drive[d] = DATA_W'(lim_neg);
					hit[d] = 1'b1;
				end else begin
					nxt.drive[d] = DATA_W'(floored[d]);
				end
			end
		end
		if (in_bundle.ctrl.compute) begin
			nxt.valid = 1'b1;
			nxt.sat = |hit;
			nxt.code = (|hit) ? STATUS_SATURATED : STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= in_bundle.ctrl.live;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= nxt;
	end

	assign done = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
	import lqr_pkg::*;

	localparam int LATENCY = 6;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] NEG_MAX = 32'h8000_0000;
	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [127:0] ALL_POS_MAX = {4{POS_MAX}};
	localparam logic [127:0] ALL_NEG_MAX = {4{NEG_MAX}};
	localparam logic [63:0] GAINS_POS_MAX = {4{16'h7FFF}};
	localparam logic [63:0] GAINS_NEG_MAX = {4{16'h8000}};

	typedef struct packed {
		logic [3:0][31:0] measured;
		logic [3:0][31:0] target;
		logic run_enable;
		logic clear_request;
	} sample_t;

	typedef struct packed {
		logic [31:0] drive_first;
		logic [31:0] drive_second;
		logic valid;
		logic sat;
		logic echo;
		logic [1:0] code;
	} drives_t;

	typedef struct packed {
		logic reconfig;
		logic [63:0] gains_first;
		logic [63:0] gains_second;
		logic [31:0] limit;
		sample_t smp;
		logic fixed;
		drives_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	sample_t req;
	logic done;
	logic signed [31:0] drive_first;
	logic signed [31:0] drive_second;
	logic drives_valid;
	logic clamped;
	logic enabled_echo;
	logic [1:0] status_code;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0] pwdata;
	logic [CFG_W-1:0] prdata;
	logic pready;

	logic [63:0] cfg_gains_first;
	logic [63:0] cfg_gains_second;
	logic [31:0] cfg_limit;
	logic gaps_on;
	drives_t pending_drives[$];
	row_t directed_rows[$];
	int fail_count;
	int idle_cycles;

	lqr_state_feedback dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.measured_0(req.measured[0]),
		.measured_1(req.measured[1]),
		.measured_2(req.measured[2]),
		.measured_3(req.measured[3]),
		.target_0(req.target[0]),
		.target_1(req.target[1]),
		.target_2(req.target[2]),
		.target_3(req.target[3]),
		.run_enable(req.run_enable),
		.clear_request(req.clear_request),
		.done(done),
		.drive_first(drive_first),
		.drive_second(drive_second),
		.drives_valid(drives_valid),
		.clamped(clamped),
		.enabled_echo(enabled_echo),
		.status_code(status_code),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic drives_t compute_drives(sample_t s);
		drives_t r;
		longint lim;
		longint acc;
		longint u;
		longint err[4];
		logic [63:0] row;
		int i;
		int d;
		r = '0;
		r.echo = s.run_enable;
		r.code = STATUS_OK;
		if (!s.clear_request && s.run_enable) begin
			lim = longint'($signed(cfg_limit));
			if (lim < 0)
				lim = -lim;
			if (lim > 64'sd2147483647)
				lim = 64'sd2147483647;
			if (lim == 0) begin
				r.code = STATUS_LIMIT_ZERO;
			end else begin
				for (i = 0; i < 4; i++)
					err[i] = longint'($signed(s.measured[i])) - longint'($signed(s.target[i]));
				for (d = 0; d < 2; d++) begin
					row = (d == 0) ? cfg_gains_first : cfg_gains_second;
					acc = 0;
					for (i = 0; i < 4; i++)
						acc += longint'($signed(row[16*i +: 16])) * err[i];
					u = (-acc) >>> 8;
					if (u > lim) begin
						u = lim;
						r.sat = 1'b1;
					end else if (u < -lim) begin
						u = -lim;
						r.sat = 1'b1;
					end
					if (d == 0)
						r.drive_first = u[31:0];
					else
						r.drive_second = u[31:0];
				end
				r.valid = 1'b1;
				if (r.sat)
					r.code = STATUS_SATURATED;
			end
		end
		return r;
	endfunction

	function automatic void add_row(logic reconfig, logic [63:0] gf, logic [63:0] gs,
			logic [31:0] lim, logic [127:0] meas, logic [127:0] targ, logic en, logic clr,
			logic fixed, logic want_valid, logic [1:0] want_code);
		row_t r;
		r = '0;
		r.reconfig = reconfig;
		r.gains_first = gf;
		r.gains_second = gs;
		r.limit = lim;
		r.smp.measured = meas;
		r.smp.target = targ;
		r.smp.run_enable = en;
		r.smp.clear_request = clr;
		r.fixed = fixed;
		r.want.valid = want_valid;
		r.want.echo = en;
		r.want.code = want_code;
		directed_rows.push_back(r);
	endfunction

	function automatic logic [31:0] random_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(0, 9))
			0: w = POS_MAX;
			1: w = NEG_MAX;
			2, 3, 4: w = {{12{w[19]}}, w[19:0]};
			default: ;
		endcase
		return w;
	endfunction

	function automatic logic [63:0] random_gain_row();
		logic [63:0] row;
		logic [15:0] g;
		int i;
		for (i = 0; i < 4; i++) begin
			g = $urandom;
			case ($urandom_range(0, 5))
				0: g = 16'h7FFF;
				1: g = 16'h8000;
				2: g = 16'h0000;
				3, 4: g = {{8{g[7]}}, g[7:0]};
				default: ;
			endcase
			row[16*i +: 16] = g;
		end
		return row;
	endfunction

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [63:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, {REG_LSB{1'b0}}};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// The registers may only change once every request in flight has produced its result.
	task automatic apply_config(logic [63:0] gf, logic [63:0] gs, logic [31:0] lim);
		start <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		write_reg(REG_GAINS_FIRST, gf);
		write_reg(REG_GAINS_SECOND, gs);
		write_reg(REG_DRIVE_LIMIT, {32'h0, lim});
		cfg_gains_first = gf;
		cfg_gains_second = gs;
		cfg_limit = lim;
	endtask

	task automatic send_sample(sample_t s);
		while (gaps_on && $urandom_range(0, 99) < 20) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= s;
		do @(posedge clk); while (busy);
	endtask

	task automatic note_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		drives_t got;
		drives_t want;
		if (arst_n && done) begin
			got = {drive_first, drive_second, drives_valid, clamped, enabled_echo, status_code};
			if (pending_drives.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = pending_drives.pop_front();
				note_field("drive_first", want.drive_first, got.drive_first);
				note_field("drive_second", want.drive_second, got.drive_second);
				note_field("drives_valid", 32'(want.valid), 32'(got.valid));
				note_field("clamped", 32'(want.sat), 32'(got.sat));
				note_field("enabled_echo", 32'(want.echo), 32'(got.echo));
				note_field("status_code", 32'(want.code), 32'(got.code));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		sample_t s;
		row_t r;
		logic [63:0] gf;
		logic [63:0] gs;
		logic [31:0] lim;
		arst_n <= 1'b0;
		start <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		idle_cycles = 0;
		fail_count = 0;
		gaps_on = 1'b1;
		cfg_gains_first = '0;
		cfg_gains_second = '0;
		cfg_limit = ONE_Q16;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 1, 1, 1, 0, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 0, 0, 1, 0, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 1, 0, 1, 1, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_NEG_MAX, ALL_POS_MAX, 0, 1, 1, 0, STATUS_OK);
		add_row(1, GAINS_POS_MAX, GAINS_NEG_MAX, 0, ALL_POS_MAX, ALL_NEG_MAX, 1, 0,
			1, 0, STATUS_LIMIT_ZERO);
		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 1, 1, 1, 0, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 0, 0, 1, 0, STATUS_OK);
		add_row(1, GAINS_POS_MAX, GAINS_NEG_MAX, NEG_MAX, ALL_POS_MAX, ALL_NEG_MAX, 1, 0,
			0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_NEG_MAX, ALL_POS_MAX, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, '0, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(1, {4{16'h0001}}, {4{16'hFFFF}}, POS_MAX, {96'h0, 32'h1}, '0, 1, 0,
			0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, {96'h0, 32'hFFFF_FFFF}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, ALL_POS_MAX, ALL_NEG_MAX, 1, 0, 0, 0, STATUS_OK);
		add_row(1, 64'h8000_7FFF_8000_7FFF, 64'h7FFF_8000_0100_FF00, 32'hFFFF_0000,
			{32'hFFFF_0000, ONE_Q16, NEG_MAX, POS_MAX},
			{32'h1234_5678, 32'h0, POS_MAX, NEG_MAX}, 1, 0, 0, 0, STATUS_OK);
		add_row(1, 64'h0000_0000_0000_0100, 64'h0000_0000_0000_FF00, ONE_Q16,
			{96'h0, ONE_Q16}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, {96'h0, 32'h0001_0001}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, {96'h0, 32'hFFFF_0000}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, {96'h0, 32'hFFFE_FFFF}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(1, 64'h0001_FFFF_0100_8000, 64'h7FFF_0001_FF00_0000, 32'h0000_0001,
			{32'h0, 32'h100, 32'hFFFF_FF00, 32'h1}, '0, 1, 0, 0, 0, STATUS_OK);
		add_row(0, 0, 0, 0, '0, '0, 1, 0, 0, 0, STATUS_OK);

		foreach (directed_rows[k]) begin
			r = directed_rows[k];
			if (r.reconfig)
				apply_config(r.gains_first, r.gains_second, r.limit);
			send_sample(r.smp);
			pending_drives.push_back(r.fixed ? r.want : compute_drives(r.smp));
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			gf = random_gain_row();
			gs = random_gain_row();
			lim = $urandom;
			case ($urandom_range(0, 7))
				0: lim = 32'h0;
				1: lim = NEG_MAX;
				2: lim = POS_MAX;
				3: lim = 32'h1;
				4, 5: lim = $urandom_range(32'h0000_1000, 32'h0100_0000);
				default: ;
			endcase
			if (ph == RANDOM_PHASES - 1)
				lim = ONE_Q16;
			apply_config(gf, gs, lim);
			gaps_on = (ph != 2) && (ph != 3);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				s.run_enable = $urandom_range(0, 9) != 0;
				s.clear_request = $urandom_range(0, 11) == 0;
				for (int i = 0; i < 4; i++) begin
					s.measured[i] = random_word();
					s.target[i] = random_word();
				end
				send_sample(s);
				pending_drives.push_back(compute_drives(s));
			end
		end

		start <= 1'b0;
		while (pending_drives.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (fail_count == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== lqr_state_feedback.f =====
+incdir+rtl/core
rtl/core/lqr_pkg.sv
rtl/core/lqr_cell.sv
rtl/core/lqr_clamp.sv
rtl/core/lqr_state_feedback.sv
tb/tb.sv
